// ----- rtl/core/odo_pkg.sv -----
`default_nettype none

package odo_pkg;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] OP_SAMPLE   = 2'd0;
	localparam logic [1:0] OP_ZERO     = 2'd1;
	localparam logic [1:0] OP_BASELINE = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_INVERT_LEFT  = 3'd0;
	localparam logic [2:0] REG_INVERT_RIGHT = 3'd1;
	localparam logic [2:0] REG_LEFT_GAIN    = 3'd2;
	localparam logic [2:0] REG_RIGHT_GAIN   = 3'd3;
	localparam logic [2:0] REG_ANGLE_GAIN   = 3'd4;

	// Full turn in heading units of 2^-16 rad.
	localparam logic [19:0] HEADING_TWO_PI = 20'd411775;

	// Angles in units of 2^-30 rad for the CORDIC.
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;

	// Inverse CORDIC gain in units of 2^-31, and the output clamp of 2^31.
	localparam logic signed [33:0] CORDIC_START = 34'sd1304065748;
	localparam logic signed [33:0] CORDIC_CLAMP = 34'sd2147483648;

	localparam int ATAN_DEPTH = 24;
	localparam int ATAN_IW    = 5;

	localparam logic [29:0] ATAN_Q30 [0:ATAN_DEPTH-1] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

	// Microseconds per second, the velocity scale.
	localparam logic [19:0] VEL_SCALE = 20'd1000000;

	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

`default_nettype wire

// ----- rtl/core/differential_drive_odometry_core.sv -----
`default_nettype none

// Dead-reckoning odometry for a two-wheel robot. Each input item carries the
// absolute left and right encoder counts and the microseconds since the last
// sample; the operation in tuser selects a sample update, a pose reset or a
// baseline capture. A sample update negates the counts if configured, takes
// the wrapped difference from the stored counts, scales both wheels by their
// gains, advances the heading modulo a full turn (the remainder keeps the
// sign of the sum), rotates the mean wheel travel through a CORDIC and
// integrates x and y with saturation. It then reports the pose together with
// the x, y, heading and wheel velocities, each rounded half away from zero
// and saturated to 32 bits. The other operations report the pose with all
// velocities zero and go through the done state to the output register.
// One item is worked on at a time. A sample update runs through one shared
// shift-and-add multiplier that retires one multiplier bit a cycle and one
// shared restoring divider that retires one quotient bit a cycle: three
// 24-bit gain products, a 50-bit heading remainder, the CORDIC (one rotation
// a cycle), two 32-bit products for x and y, and for each of the five
// velocities a 20-bit product by one million followed by a 32-bit division
// by the elapsed time. The finished result waits in an output register, so
// the next item is accepted while it is still waiting to be taken.
// Configuration writes are registered and are meant to be issued only while
// the block is idle.
module differential_drive_odometry_core #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Configuration write port.
	input  wire logic         cfg_wr_en,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [23:0]  cfg_data,
	// Input items.
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [31:0] left_count, [63:32] right_count, [83:64] elapsed_us, [87:84] zero
	input  wire logic [87:0]  s_axis_tdata,
	// [1:0] operation
	input  wire logic [1:0]   s_axis_tuser,
	// Result items.
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [31:0] pose_x, [63:32] pose_y, [83:64] heading, [115:84] speed_x,
	// [147:116] speed_y, [179:148] turn_rate, [211:180] left_speed,
	// [243:212] right_speed, [247:244] zero
	output logic [247:0]      m_axis_tdata
);

	import odo_pkg::*;

	// Shift between the exact product units and the Q format of each result.
	localparam int SHX = 56 - FRAC_BITS;
	localparam int SHT = 48 - FRAC_BITS;
	localparam int SHW = 24 - FRAC_BITS;
	localparam int CW  = $clog2(CORDIC_STEPS + 1);

	// Multiplicand, product and dividend widths.
	localparam int AW = 87;
	localparam int PW = 108;
	localparam int DW = 50;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DL   = 4'd1;
	localparam logic [3:0] ST_DR   = 4'd2;
	localparam logic [3:0] ST_AM   = 4'd3;
	localparam logic [3:0] ST_MOD  = 4'd4;
	localparam logic [3:0] ST_CORD = 4'd5;
	localparam logic [3:0] ST_MX   = 4'd6;
	localparam logic [3:0] ST_MY   = 4'd7;
	localparam logic [3:0] ST_VMUL = 4'd8;
	localparam logic [3:0] ST_VDIV = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0] state_q;

	// Configuration.
	logic        inv_l_q, inv_r_q;
	logic [23:0] lgain_q, rgain_q, again_q;

	// Architectural state.
	logic [31:0] prev_l_q, prev_r_q;
	logic [31:0] pos_x_q, pos_y_q;
	logic [19:0] heading_q;

	// Per-item working registers.
	logic [31:0] cur_l_q, cur_r_q, ddr_q;
	logic [19:0] e_q;
	logic        dl_neg_q, dr_neg_q, diff_neg_q, hv_neg_q, flip_q, vsat_q;
	logic [54:0] dl_mag_q, dr_mag_q;
	logic [56:0] sum_q;
	logic [79:0] am_q;
	logic [AW-1:0] mx_q, my_q;
	logic [32:0] cs_q, sn_q;
	logic [2:0]  vsel_q;
	logic [31:0] vel_q [0:4];

	// Shared bit-serial multiplier.
	logic [AW-1:0] ma_q;
	logic [31:0]   mb_q;
	logic [PW-1:0] mp_q;
	logic [5:0]    mcnt_q;

	// Shared restoring divider.
	logic [DW-1:0] dd_q;
	logic [19:0]   drem_q, ddiv_q;
	logic [31:0]   dq_q;
	logic [5:0]    dcnt_q;

	// CORDIC.
	logic signed [33:0] cx_q, cy_q;
	logic signed [35:0] cz_q;
	logic [CW-1:0]      ci_q;

	logic         out_valid_q;
	logic [247:0] out_data_q;

	// Input fields.
	logic [31:0] in_left, in_right;
	logic [19:0] in_elapsed;
	logic [1:0]  in_op;

	logic [31:0] cl_n, cr_n, ddl_w, ddr_w, ddl_abs, ddr_abs;
	logic [PW-1:0] mp_step;
	logic [56:0] dl_s, dr_s, sum_w, diff_w, diff_t, sum_t;
	logic [55:0] diff_abs, sum_abs;
	logic [80:0] inc_t;
	logic [48:0] inc_w;
	logic [50:0] hv_w, hv_t;
	logic [49:0] hv_abs;
	logic [20:0] dt, dsub;
	logic        dge;
	logic [19:0] drem_nx, h_new;
	logic signed [35:0] z0, z1, z2, z3, atan_w;
	logic        flip_w;
	logic signed [33:0] cx_sh, cy_sh, cx_c, cy_c;
	logic signed [32:0] cs_w, sn_w;
	logic [32:0] cs_t, sn_t;
	logic [31:0] cs_abs, sn_abs;
	logic        sx_neg, sy_neg, pneg;
	logic [87:0] pd_t, pd;
	logic [31:0] pbase;
	logic signed [57:0] ps;
	logic [31:0] pos_new;
	logic [109:0] ev, s2, ap;
	logic        vsat_w, vneg, vbig;
	logic [31:0] vres;
	logic [2:0]  vnext;
	logic [AW-1:0] vm_next;

	assign in_left    = s_axis_tdata[31:0];
	assign in_right   = s_axis_tdata[63:32];
	assign in_elapsed = s_axis_tdata[83:64];
	assign in_op      = s_axis_tuser;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		// Count differences, wrapping in 32 bits.
		cl_n    = inv_l_q ? 32'd0 - in_left : in_left;
		cr_n    = inv_r_q ? 32'd0 - in_right : in_right;
		ddl_w   = cl_n - prev_l_q;
		ddr_w   = cr_n - prev_r_q;
		ddl_abs = ddl_w[31] ? 32'd0 - ddl_w : ddl_w;
		ddr_abs = ddr_q[31] ? 32'd0 - ddr_q : ddr_q;

		// One multiplier bit per cycle, most significant first.
		mp_step = {mp_q[PW-2:0], 1'b0} + (mb_q[31] ? PW'(ma_q) : PW'(0));

		// Signed wheel travels and their sum and difference.
		dl_s     = dl_neg_q ? 57'd0 - 57'(dl_mag_q) : 57'(dl_mag_q);
		dr_s     = dr_neg_q ? 57'd0 - 57'(mp_q[54:0]) : 57'(mp_q[54:0]);
		sum_w    = dl_s + dr_s;
		diff_w   = dl_s - dr_s;
		diff_t   = diff_w[56] ? 57'd0 - diff_w : diff_w;
		diff_abs = diff_t[55:0];
		sum_t    = sum_q[56] ? 57'd0 - sum_q : sum_q;
		sum_abs  = sum_t[55:0];

		// Heading step rounded to 2^-16 rad, added to the heading.
		inc_t  = 81'(mp_q[79:0]) + (81'd1 << 31);
		inc_w  = inc_t[80:32];
		hv_w   = {{31{heading_q[19]}}, heading_q}
			+ (diff_neg_q ? 51'd0 - 51'(inc_w) : 51'(inc_w));
		hv_t   = hv_w[50] ? 51'd0 - hv_w : hv_w;
		hv_abs = hv_t[49:0];

		// Restoring divider step.
		dt      = {drem_q, dd_q[DW-1]};
		dge     = (dt >= {1'b0, ddiv_q});
		dsub    = dt - {1'b0, ddiv_q};
		drem_nx = dge ? dsub[19:0] : dt[19:0];

		// New heading and the CORDIC starting angle in [-pi/2, pi/2].
		h_new  = hv_neg_q ? 20'd0 - drem_q : drem_q;
		z0     = $signed({{2{h_new[19]}}, h_new, 14'd0});
		z1     = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 : z0;
		z2     = (z1 < -PI_Q30) ? z1 + TWO_PI_Q30 : z1;
		flip_w = 1'b0;
		z3     = z2;
		if (z2 > HALF_PI_Q30) begin
			z3     = z2 - PI_Q30;
			flip_w = 1'b1;
		end else if (z2 < -HALF_PI_Q30) begin
			z3     = z2 + PI_Q30;
			flip_w = 1'b1;
		end

		// One rotation per cycle; the arithmetic shift floors.
		cx_sh  = cx_q >>> ci_q;
		cy_sh  = cy_q >>> ci_q;
		atan_w = $signed({6'd0, ATAN_Q30[ATAN_IW'(ci_q)]});

		cx_c = (cx_q > CORDIC_CLAMP) ? CORDIC_CLAMP
			: ((cx_q < -CORDIC_CLAMP) ? -CORDIC_CLAMP : cx_q);
		cy_c = (cy_q > CORDIC_CLAMP) ? CORDIC_CLAMP
			: ((cy_q < -CORDIC_CLAMP) ? -CORDIC_CLAMP : cy_q);
		cs_w   = flip_q ? -$signed(cx_c[32:0]) : $signed(cx_c[32:0]);
		sn_w   = flip_q ? -$signed(cy_c[32:0]) : $signed(cy_c[32:0]);
		cs_t   = cs_w[32] ? 33'd0 - cs_w : cs_w;
		cs_abs = cs_t[31:0];
		sn_t   = sn_q[32] ? 33'd0 - sn_q : sn_q;
		sn_abs = sn_t[31:0];

		sx_neg = sum_q[56] ^ cs_q[32];
		sy_neg = sum_q[56] ^ sn_q[32];

		// Position step rounded half up in magnitude, then saturating add.
		pneg  = (state_q == ST_MY) ? sy_neg : sx_neg;
		pbase = (state_q == ST_MY) ? pos_y_q : pos_x_q;
		pd_t  = 88'(mp_q[AW-1:0]) + (88'd1 << (SHX - 1));
		pd    = pd_t >> SHX;
		ps    = $signed({{26{pbase[31]}}, pbase})
			+ $signed(pneg ? 58'd0 - pd[57:0] : pd[57:0]);
		if (ps > 58'sd2147483647) begin
			pos_new = SAT_POS;
		end else if (ps < -58'sd2147483648) begin
			pos_new = SAT_NEG;
		end else begin
			pos_new = ps[31:0];
		end

		// Velocity: round(m * 1e6 / (e * 2^sh)) as floor(floor((2N + e*2^sh)
		// / 2^(sh+1)) / e), the last division left to the divider.
		case (vsel_q) inside
			3'd0, 3'd1: ev = 110'(e_q) << SHX;
			3'd2:       ev = 110'(e_q) << SHT;
			default:    ev = 110'(e_q) << SHW;
		endcase
		s2 = {1'b0, mp_q, 1'b0} + ev;
		case (vsel_q) inside
			3'd0, 3'd1: ap = s2 >> (SHX + 1);
			3'd2:       ap = s2 >> (SHT + 1);
			default:    ap = s2 >> (SHW + 1);
		endcase
		vsat_w = (|ap[109:52]) || (ap[51:32] >= e_q);

		case (vsel_q)
			3'd0:    vneg = sx_neg;
			3'd1:    vneg = sy_neg;
			3'd2:    vneg = diff_neg_q;
			3'd3:    vneg = dl_neg_q;
			default: vneg = dr_neg_q;
		endcase
		vbig = vsat_q || dq_q[31];
		if (vbig) begin
			vres = vneg ? SAT_NEG : SAT_POS;
		end else begin
			vres = vneg ? 32'd0 - dq_q : dq_q;
		end

		vnext = vsel_q + 3'd1;
		case (vnext)
			3'd1:    vm_next = my_q;
			3'd2:    vm_next = AW'(am_q);
			3'd3:    vm_next = AW'(dl_mag_q);
			3'd4:    vm_next = AW'(dr_mag_q);
			default: vm_next = mx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inv_l_q     <= 1'b0;
			inv_r_q     <= 1'b0;
			lgain_q     <= '0;
			rgain_q     <= '0;
			again_q     <= '0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			heading_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			cur_l_q     <= '0;
			cur_r_q     <= '0;
			ddr_q       <= '0;
			e_q         <= '0;
			dl_neg_q    <= 1'b0;
			dr_neg_q    <= 1'b0;
			diff_neg_q  <= 1'b0;
			hv_neg_q    <= 1'b0;
			flip_q      <= 1'b0;
			vsat_q      <= 1'b0;
			dl_mag_q    <= '0;
			dr_mag_q    <= '0;
			sum_q       <= '0;
			am_q        <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			cs_q        <= '0;
			sn_q        <= '0;
			vsel_q      <= '0;
			for (int i = 0; i < 5; i++) vel_q[i] <= '0;
			ma_q        <= '0;
			mb_q        <= '0;
			mp_q        <= '0;
			mcnt_q      <= '0;
			dd_q        <= '0;
			drem_q      <= '0;
			ddiv_q      <= '0;
			dq_q        <= '0;
			dcnt_q      <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			cz_q        <= '0;
			ci_q        <= '0;
		end else begin
			// A result that is taken clears the output, unless a new one is loaded.
			if (out_valid_q && m_axis_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_INVERT_LEFT:  inv_l_q <= cfg_data[0];
					REG_INVERT_RIGHT: inv_r_q <= cfg_data[0];
					REG_LEFT_GAIN:    lgain_q <= cfg_data;
					REG_RIGHT_GAIN:   rgain_q <= cfg_data;
					REG_ANGLE_GAIN:   again_q <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						e_q     <= (in_elapsed == 20'd0) ? 20'd1 : in_elapsed;
						cur_l_q <= cl_n;
						cur_r_q <= cr_n;
						ddr_q   <= ddr_w;
						for (int i = 0; i < 5; i++) vel_q[i] <= '0;
						unique case (in_op)
							OP_SAMPLE: begin
								dl_neg_q <= ddl_w[31];
								ma_q     <= AW'(ddl_abs);
								mb_q     <= {lgain_q, 8'd0};
								mp_q     <= '0;
								mcnt_q   <= 6'd24;
								state_q  <= ST_DL;
							end
							OP_ZERO: begin
								pos_x_q   <= '0;
								pos_y_q   <= '0;
								heading_q <= '0;
								state_q   <= ST_DONE;
							end
							OP_BASELINE: begin
								prev_l_q <= cl_n;
								prev_r_q <= cr_n;
								state_q  <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end

				ST_DL: begin
					if (mcnt_q != 6'd0) begin
						mp_q   <= mp_step;
						mb_q   <= {mb_q[30:0], 1'b0};
						mcnt_q <= mcnt_q - 6'd1;
					end else begin
						dl_mag_q <= mp_q[54:0];
						dr_neg_q <= ddr_q[31];
						ma_q     <= AW'(ddr_abs);
						mb_q     <= {rgain_q, 8'd0};
						mp_q     <= '0;
						mcnt_q   <= 6'd24;
						state_q  <= ST_DR;
					end
				end

				ST_DR: begin
					if (mcnt_q != 6'd0) begin
						mp_q   <= mp_step;
						mb_q   <= {mb_q[30:0], 1'b0};
						mcnt_q <= mcnt_q - 6'd1;
					end else begin
						dr_mag_q   <= mp_q[54:0];
						sum_q      <= sum_w;
						diff_neg_q <= diff_w[56];
						ma_q       <= AW'(diff_abs);
						mb_q       <= {again_q, 8'd0};
						mp_q       <= '0;
						mcnt_q     <= 6'd24;
						state_q    <= ST_AM;
					end
				end

				ST_AM: begin
					if (mcnt_q != 6'd0) begin
						mp_q   <= mp_step;
						mb_q   <= {mb_q[30:0], 1'b0};
						mcnt_q <= mcnt_q - 6'd1;
					end else begin
						am_q     <= mp_q[79:0];
						hv_neg_q <= hv_w[50];
						dd_q     <= hv_abs;
						drem_q   <= '0;
						ddiv_q   <= HEADING_TWO_PI;
						dcnt_q   <= 6'(DW);
						state_q  <= ST_MOD;
					end
				end

				ST_MOD: begin
					if (dcnt_q != 6'd0) begin
						drem_q <= drem_nx;
						dd_q   <= {dd_q[DW-2:0], 1'b0};
						dq_q   <= {dq_q[30:0], dge};
						dcnt_q <= dcnt_q - 6'd1;
					end else begin
						heading_q <= h_new;
						cz_q      <= z3;
						flip_q    <= flip_w;
						cx_q      <= CORDIC_START;
						cy_q      <= '0;
						ci_q      <= '0;
						state_q   <= ST_CORD;
					end
				end

				ST_CORD: begin
					if (ci_q != CW'(CORDIC_STEPS)) begin
						if (!cz_q[35]) begin
							cx_q <= cx_q - cy_sh;
							cy_q <= cy_q + cx_sh;
							cz_q <= cz_q - atan_w;
						end else begin
							cx_q <= cx_q + cy_sh;
							cy_q <= cy_q - cx_sh;
							cz_q <= cz_q + atan_w;
						end
						ci_q <= ci_q + CW'(1);
					end else begin
						cs_q    <= cs_w;
						sn_q    <= sn_w;
						ma_q    <= AW'(sum_abs);
						mb_q    <= cs_abs;
						mp_q    <= '0;
						mcnt_q  <= 6'd32;
						state_q <= ST_MX;
					end
				end

				ST_MX: begin
					if (mcnt_q != 6'd0) begin
						mp_q   <= mp_step;
						mb_q   <= {mb_q[30:0], 1'b0};
						mcnt_q <= mcnt_q - 6'd1;
					end else begin
						mx_q    <= mp_q[AW-1:0];
						pos_x_q <= pos_new;
						ma_q    <= AW'(sum_abs);
						mb_q    <= sn_abs;
						mp_q    <= '0;
						mcnt_q  <= 6'd32;
						state_q <= ST_MY;
					end
				end

				ST_MY: begin
					if (mcnt_q != 6'd0) begin
						mp_q   <= mp_step;
						mb_q   <= {mb_q[30:0], 1'b0};
						mcnt_q <= mcnt_q - 6'd1;
					end else begin
						my_q    <= mp_q[AW-1:0];
						pos_y_q <= pos_new;
						vsel_q  <= '0;
						ma_q    <= mx_q;
						mb_q    <= {VEL_SCALE, 12'd0};
						mp_q    <= '0;
						mcnt_q  <= 6'd20;
						state_q <= ST_VMUL;
					end
				end

				ST_VMUL: begin
					if (mcnt_q != 6'd0) begin
						mp_q   <= mp_step;
						mb_q   <= {mb_q[30:0], 1'b0};
						mcnt_q <= mcnt_q - 6'd1;
					end else begin
						// The integer part above bit 32 seeds the remainder.
						vsat_q  <= vsat_w;
						drem_q  <= ap[51:32];
						dd_q    <= {ap[31:0], 18'd0};
						ddiv_q  <= e_q;
						dcnt_q  <= 6'd32;
						state_q <= ST_VDIV;
					end
				end

				ST_VDIV: begin
					if (dcnt_q != 6'd0) begin
						drem_q <= drem_nx;
						dd_q   <= {dd_q[DW-2:0], 1'b0};
						dq_q   <= {dq_q[30:0], dge};
						dcnt_q <= dcnt_q - 6'd1;
					end else begin
						vel_q[vsel_q] <= vres;
						if (vsel_q == 3'd4) begin
							prev_l_q <= cur_l_q;
							prev_r_q <= cur_r_q;
							state_q  <= ST_DONE;
						end else begin
							vsel_q  <= vnext;
							ma_q    <= vm_next;
							mb_q    <= {VEL_SCALE, 12'd0};
							mp_q    <= '0;
							mcnt_q  <= 6'd20;
							state_q <= ST_VMUL;
						end
					end
				end

				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {4'd0, vel_q[4], vel_q[3], vel_q[2], vel_q[1],
							vel_q[0], heading_q, pos_y_q, pos_x_q};
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/odo_checker.sv -----
`default_nettype none

module odo_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [247:0] m_axis_tdata
);

	import odo_pkg::*;

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// One item at a time: the input closes right after an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input still open after accepting an item");

	// A new result only appears after the block has been busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared without work in progress");

	// The reported heading stays below a full turn in magnitude.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			($signed(m_axis_tdata[83:64]) < $signed(HEADING_TWO_PI)) &&
			($signed(m_axis_tdata[83:64]) > -$signed(HEADING_TWO_PI)))
		else $error("heading out of range");

endmodule

bind differential_drive_odometry_core odo_checker u_odo_checker (.*);

`default_nettype wire

// ----- verif/differential_drive_odometry_core_test.sv -----
`timescale 1ns / 1ps

module differential_drive_odometry_core_test;
	import odo_pkg::*;

	// The fourth operation code is not named by the package; it must leave the state alone.
	localparam logic [1:0] OP_NONE = 2'd3;
	// The limit covers a sample update plus a long receiver stall.
	localparam int STALL_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 600;
	localparam int LONG_HOLD = 3000;
	localparam longint TURN = 411775;

	// One result item, split into its fields.
	typedef struct {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [19:0] heading;
		logic signed [31:0] speed_x;
		logic signed [31:0] speed_y;
		logic signed [31:0] turn_rate;
		logic signed [31:0] left_speed;
		logic signed [31:0] right_speed;
	} pose_report_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [247:0] m_axis_tdata;

	// Our own copy of the odometry state and the configuration registers.
	logic [31:0] last_left, last_right;
	logic signed [31:0] track_x, track_y;
	logic signed [19:0] track_heading;
	logic inv_left, inv_right;
	logic [23:0] gain_left, gain_right, gain_angle;

	pose_report_t pending_poses[$];
	int error_count;
	int idle_cycles;
	int burst_left;
	bit gaps_on;
	int hold_request, hold_seen, hold_count;
	int rx_mode, rx_mode_timer;
	// Raw counts of the last item sent, used to build small, realistic wheel steps.
	logic [31:0] sent_left, sent_right;

	differential_drive_odometry_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	// Rounded quotient m * c / (e * 2^sh), halves away from zero on the magnitude,
	// with the magnitude capped at 2^62 before the final 32-bit saturation.
	function automatic logic [63:0] scaled_mag(logic [127:0] m, logic [19:0] c,
			logic [19:0] e, int sh);
		logic [191:0] num, den, quo;
		den = {172'b0, e} << sh;
		num = (({64'b0, m} * {172'b0, c}) << 1) + den;
		quo = num / (den << 1);
		if (quo > (192'd1 << 62))
			return 64'd1 << 62;
		return quo[63:0];
	endfunction

	function automatic longint signed_mag(bit neg, logic [63:0] mag);
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Cosine and sine of a heading in units of 2^-16 rad, results in units of 2^-31.
	task automatic heading_to_cos_sin(input longint h, output longint cs, output longint sn);
		longint z, x, y, t;
		bit flip;
		z = h * 16384;
		x = CORDIC_START;
		y = 0;
		flip = 0;
		if (z > PI_Q30)
			z -= TWO_PI_Q30;
		if (z < -PI_Q30)
			z += TWO_PI_Q30;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < 16 && i < ATAN_DEPTH; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_Q30[i]);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_Q30[i]);
			end
			x = t;
		end
		if (x > 64'sd2147483648) x = 64'sd2147483648;
		if (x < -64'sd2147483648) x = -64'sd2147483648;
		if (y > 64'sd2147483648) y = 64'sd2147483648;
		if (y < -64'sd2147483648) y = -64'sd2147483648;
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endtask

	// Advances the tracked pose by one accepted item and queues the report it should give.
	task automatic track_odometry(logic [1:0] op, logic [31:0] raw_l, logic [31:0] raw_r,
			logic [19:0] usec);
		logic [31:0] cl, cr;
		logic [19:0] e;
		longint dl, dr, diff, sum, inc, hsum, cs, sn, dx, dy;
		longint vx, vy, turn, vl, vr;
		logic [127:0] am, mx, my;
		pose_report_t rep;
		cl = inv_left ? -raw_l : raw_l;
		cr = inv_right ? -raw_r : raw_r;
		e = (usec == 0) ? 20'd1 : usec;
		vx = 0; vy = 0; turn = 0; vl = 0; vr = 0;
		if (op == OP_SAMPLE) begin
			dl = longint'($signed(cl - last_left)) * longint'({40'b0, gain_left});
			dr = longint'($signed(cr - last_right)) * longint'({40'b0, gain_right});
			diff = dl - dr;
			sum = dl + dr;
			am = {64'b0, magnitude(diff)} * {104'b0, gain_angle};
			inc = signed_mag(diff < 0, scaled_mag(am, 20'd1, 20'd1, 32));
			hsum = longint'(track_heading) + inc;
			track_heading = 20'(hsum % TURN);
			heading_to_cos_sin(longint'(track_heading), cs, sn);
			mx = {64'b0, magnitude(sum)} * {64'b0, magnitude(cs)};
			my = {64'b0, magnitude(sum)} * {64'b0, magnitude(sn)};
			dx = signed_mag((sum < 0) != (cs < 0), scaled_mag(mx, 20'd1, 20'd1, 40));
			dy = signed_mag((sum < 0) != (sn < 0), scaled_mag(my, 20'd1, 20'd1, 40));
			vx = signed_mag((sum < 0) != (cs < 0), scaled_mag(mx, VEL_SCALE, e, 40));
			vy = signed_mag((sum < 0) != (sn < 0), scaled_mag(my, VEL_SCALE, e, 40));
			turn = signed_mag(diff < 0, scaled_mag(am, VEL_SCALE, e, 32));
			vl = signed_mag(dl < 0, scaled_mag({64'b0, magnitude(dl)}, VEL_SCALE, e, 8));
			vr = signed_mag(dr < 0, scaled_mag({64'b0, magnitude(dr)}, VEL_SCALE, e, 8));
			track_x = clip32(longint'(track_x) + dx);
			track_y = clip32(longint'(track_y) + dy);
			last_left = cl;
			last_right = cr;
		end else if (op == OP_ZERO) begin
			track_x = 0;
			track_y = 0;
			track_heading = 0;
		end else if (op == OP_BASELINE) begin
			last_left = cl;
			last_right = cr;
		end
		rep.pose_x = track_x;
		rep.pose_y = track_y;
		rep.heading = track_heading;
		rep.speed_x = clip32(vx);
		rep.speed_y = clip32(vy);
		rep.turn_rate = clip32(turn);
		rep.left_speed = clip32(vl);
		rep.right_speed = clip32(vr);
		pending_poses.push_back(rep);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Sends one item and waits for the block to take it. The valid stays high after
	// acceptance so that back-to-back items keep it steady; gaps end a burst.
	task automatic send_sample(logic [1:0] op, logic [31:0] l, logic [31:0] r, logic [19:0] us);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'b0, us, r, l};
		do @(posedge clk); while (!s_axis_tready);
		track_odometry(op, l, r, us);
		sent_left = l;
		sent_right = r;
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
				burst_left = $urandom_range(1, 6);
			end
		end
	endtask

	// Waits until every queued report has come back, with the input idle.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_INVERT_LEFT: inv_left = value[0];
			REG_INVERT_RIGHT: inv_right = value[0];
			REG_LEFT_GAIN: gain_left = value;
			REG_RIGHT_GAIN: gain_right = value;
			REG_ANGLE_GAIN: gain_angle = value;
			default: ;
		endcase
	endtask

	task automatic configure(logic il, logic ir, logic [23:0] gl, logic [23:0] gr,
			logic [23:0] ga);
		write_reg(REG_INVERT_LEFT, {23'b0, il});
		write_reg(REG_INVERT_RIGHT, {23'b0, ir});
		write_reg(REG_LEFT_GAIN, gl);
		write_reg(REG_RIGHT_GAIN, gr);
		write_reg(REG_ANGLE_GAIN, ga);
	endtask

	// One random item. Most are samples, mostly with a small wheel step from the last counts
	// and some with wild jumps; the rest are pose resets, baseline captures and the unused code.
	task automatic send_random();
		int pick;
		logic [31:0] l, r;
		logic [19:0] us;
		pick = $urandom_range(0, 99);
		l = sent_left + 32'($signed($urandom_range(0, 4000)) - 2000);
		r = sent_right + 32'($signed($urandom_range(0, 4000)) - 2000);
		us = 20'($urandom_range(1000, 20000));
		if (pick < 8) begin
			l = $urandom;
			r = $urandom;
			us = 20'($urandom);
		end
		if (pick < 78)
			send_sample(OP_SAMPLE, l, r, us);
		else if (pick < 88)
			send_sample(OP_BASELINE, l, r, us);
		else if (pick < 95)
			send_sample(OP_ZERO, l, r, us);
		else
			send_sample(OP_NONE, l, r, us);
	endtask

	// With all gains zero after reset, every sample reports zeros but still moves the baseline.
	task automatic test_reset_state();
		send_sample(OP_SAMPLE, 32'd1000, 32'd2000, 20'd5000);
		send_sample(OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 20'd1);
		drain_results();
	endtask

	// Field extremes, every operation, zero and maximum elapsed times, inversion.
	task automatic test_directed();
		configure(1'b0, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_sample(OP_BASELINE, 32'd0, 32'd0, 20'd1);
		send_sample(OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 20'd0);
		send_sample(OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 20'hFFFFF);
		send_sample(OP_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001, 20'd1000000);
		send_sample(OP_NONE, 32'h1234_5678, 32'h9ABC_DEF0, 20'd7);
		send_sample(OP_SAMPLE, 32'h0000_0010, 32'hFFFF_FFF0, 20'd1);
		send_sample(OP_ZERO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
		send_sample(OP_SAMPLE, 32'h0000_0010, 32'hFFFF_FFF0, 20'd3);
		drain_results();
		configure(1'b1, 1'b1, 24'd167772, 24'd167772, 24'd1000000);
		send_sample(OP_BASELINE, 32'h8000_0000, 32'h7FFF_FFFF, 20'd1);
		send_sample(OP_SAMPLE, 32'h8000_0100, 32'h7FFF_FF00, 20'd10000);
		send_sample(OP_SAMPLE, 32'h8000_0000, 32'h8000_0000, 20'd0);
		send_sample(OP_SAMPLE, 32'h0000_0000, 32'h0000_0000, 20'hFFFFF);
		drain_results();
		// Left wheel only, with the right gain zero, to turn the robot.
		configure(1'b0, 1'b1, 24'd300000, 24'd0, 24'd8000000);
		for (int k = 0; k < 6; k++)
			send_sample(OP_SAMPLE, sent_left + 32'd5000, 32'd0, 20'd2000);
		drain_results();
	endtask

	// Several register settings with random items in between.
	task automatic test_random_phases();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(1'b0, 1'b0, 24'd100000, 24'd100000, 24'd200000);
				1: configure(1'b1, 1'b0, 24'($urandom), 24'($urandom), 24'($urandom));
				2: configure(1'b0, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
				3: configure(1'b1, 1'b1, 24'd0, 24'd0, 24'd0);
				default: configure(1'($urandom), 1'($urandom), 24'($urandom_range(0, 2000000)),
					24'($urandom_range(0, 2000000)), 24'($urandom));
			endcase
			gaps_on = (ph % 3) != 2;
			for (int k = 0; k < 75; k++)
				send_random();
			drain_results();
		end
		gaps_on = 1;
	endtask

	// The receiver stops for a long stretch while items keep coming, so the block
	// fills its output register and must refuse further input.
	task automatic test_output_stall();
		hold_request++;
		gaps_on = 0;
		for (int k = 0; k < 5; k++)
			send_random();
		gaps_on = 1;
		drain_results();
	endtask

	// Receiver stall pattern, which changes mode now and then.
	always @(posedge clk) begin
		if (hold_request != hold_seen) begin
			hold_seen <= hold_request;
			hold_count <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_count > 0) begin
			hold_count <= hold_count - 1;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom);
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
		if (rx_mode_timer == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_mode_timer <= $urandom_range(50, 2000);
		end else begin
			rx_mode_timer <= rx_mode_timer - 1;
		end
	end

	// Compares each accepted result with the oldest queued report.
	always @(posedge clk) begin
		pose_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_poses.size() == 0) begin
				$display("UNEXPECTED result item at %0t", $realtime);
				error_count++;
			end else begin
				want = pending_poses.pop_front();
				if (m_axis_tdata[31:0] !== want.pose_x)
					report_mismatch("pose_x", m_axis_tdata[31:0], want.pose_x);
				if (m_axis_tdata[63:32] !== want.pose_y)
					report_mismatch("pose_y", m_axis_tdata[63:32], want.pose_y);
				if (m_axis_tdata[83:64] !== want.heading)
					report_mismatch("heading", {12'b0, m_axis_tdata[83:64]},
						{12'b0, want.heading});
				if (m_axis_tdata[115:84] !== want.speed_x)
					report_mismatch("speed_x", m_axis_tdata[115:84], want.speed_x);
				if (m_axis_tdata[147:116] !== want.speed_y)
					report_mismatch("speed_y", m_axis_tdata[147:116], want.speed_y);
				if (m_axis_tdata[179:148] !== want.turn_rate)
					report_mismatch("turn_rate", m_axis_tdata[179:148], want.turn_rate);
				if (m_axis_tdata[211:180] !== want.left_speed)
					report_mismatch("left_speed", m_axis_tdata[211:180], want.left_speed);
				if (m_axis_tdata[243:212] !== want.right_speed)
					report_mismatch("right_speed", m_axis_tdata[243:212], want.right_speed);
			end
		end
	end

	// Watchdog: counts cycles in which no item moves on either side and no register is written.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_SAMPLE;
		m_axis_tready = 1'b0;
		last_left = 0; last_right = 0;
		track_x = 0; track_y = 0; track_heading = 0;
		inv_left = 0; inv_right = 0;
		gain_left = 0; gain_right = 0; gain_angle = 0;
		error_count = 0;
		idle_cycles = 0;
		burst_left = 3;
		gaps_on = 1;
		hold_request = 0; hold_seen = 0; hold_count = 0;
		rx_mode = 0; rx_mode_timer = 100;
		sent_left = 0; sent_right = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed();
		test_random_phases();
		test_output_stall();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_poses.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
